// File: design/sabs_pkg.sv
// Shared constants and control types for the sorted array binary search block
`timescale 1ns / 1ps

package sabs_pkg;

  // Default store depth
  localparam int unsigned DEPTH_DEF = 1024;

  // Fixed field widths
  localparam int unsigned MODE_W  = 1;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned COUNT_W = 11;

  // Configuration port
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam logic        REG_ELEMENT_COUNT = 1'b0;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_WRITE  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic mem_write;    // store the accepted element
    logic load_query;   // latch target, open the full range
    logic probe;        // read the middle entry of the range
    logic cmp_step;     // narrow the range or record a match
    logic load_result;  // move the outcome into the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic range_empty;  // nothing left to probe
    logic eq;           // probed entry equals the target
  } sts_t;

endpackage

// File: design/sabs_query_if.sv
// Query channel: valid/ready handshake carrying mode, slot and value
`timescale 1ns / 1ps

interface sabs_query_if;
  logic                                 valid;
  logic                                 ready;
  logic [sabs_pkg::MODE_W-1:0]          mode;
  logic [sabs_pkg::SLOT_W-1:0]          slot;
  logic signed [sabs_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output slot, output value, input ready);
  modport sink   (input valid, input mode, input slot, input value, output ready);
endinterface

// File: design/sabs_result_if.sv
// Result channel: valid/ready handshake carrying found and position
`timescale 1ns / 1ps

interface sabs_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [sabs_pkg::POS_W-1:0]  position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

// File: design/sabs_datapath.sv
// Datapath: element store, search range registers, comparator and result register
`timescale 1ns / 1ps

module sabs_datapath #(
  parameter int unsigned DEPTH = sabs_pkg::DEPTH_DEF,
  parameter int unsigned IW    = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  sabs_pkg::cmd_t                      cmd_i,
  output sabs_pkg::sts_t                      sts_o,
  input  logic [IW-1:0]                       count_i,
  input  logic [sabs_pkg::SLOT_W-1:0]         slot_i,
  input  logic signed [sabs_pkg::VALUE_W-1:0] value_i,
  output logic                                found_o,
  output logic [sabs_pkg::POS_W-1:0]          position_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = (IW > sabs_pkg::SLOT_W) ? IW : sabs_pkg::SLOT_W;
  localparam int unsigned PW = (IW > sabs_pkg::POS_W) ? IW : sabs_pkg::POS_W;

  logic signed [sabs_pkg::VALUE_W-1:0] store [DEPTH];

  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid, span;
  logic signed [sabs_pkg::VALUE_W-1:0] rdata_q, target_q;
  logic          match_q, match_d;
  logic          found_q;
  logic [sabs_pkg::POS_W-1:0] pos_q;
  logic [SW-1:0] slot_ext;
  logic [PW-1:0] mid_ext;
  logic          slot_ok;

  // Drop writes beyond the store
  assign slot_ext = SW'(slot_i);
  assign slot_ok  = slot_ext < SW'(DEPTH);

  // Middle of the range [lo, hi)
  assign span = hi_q - lo_q - IW'(1);
  assign mid  = lo_q + (span >> 1);

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write && slot_ok) begin
      store[slot_ext[AW-1:0]] <= value_i;
    end
    if (cmd_i.probe) begin
      rdata_q <= store[mid[AW-1:0]];
      mid_q   <= mid;
    end
  end

  // Range update
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    match_d = match_q;
    if (cmd_i.load_query) begin
      lo_d    = '0;
      hi_d    = count_i;
      match_d = 1'b0;
    end else if (cmd_i.cmp_step) begin
      if (rdata_q == target_q) begin
        match_d = 1'b1;
      end else if (rdata_q < target_q) begin
        lo_d = mid_q + IW'(1);
      end else begin
        hi_d = mid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    match_q <= match_d;
    if (cmd_i.load_query) begin
      target_q <= value_i;
    end
  end

  // Result register
  assign mid_ext = PW'(mid_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      found_q <= match_q;
      pos_q   <= match_q ? mid_ext[sabs_pkg::POS_W-1:0] : '0;
    end
  end

  assign sts_o.range_empty = lo_q >= hi_q;
  assign sts_o.eq          = rdata_q == target_q;
  assign found_o           = found_q;
  assign position_o        = pos_q;

endmodule

// File: design/sabs_controller.sv
// Controller: sequences store writes, search probes and result hand-off
`timescale 1ns / 1ps

module sabs_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sabs_pkg::MODE_W-1:0] in_mode_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sabs_pkg::cmd_t              cmd_o,
  input  sabs_pkg::sts_t              sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PROBE  = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_mode_i == sabs_pkg::MODE_SEARCH) begin
            cmd_o.load_query = 1'b1;
            state_d          = ST_PROBE;
          end else begin
            cmd_o.mem_write = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts_i.range_empty) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp_step = 1'b1;
        state_d        = sts_i.eq ? ST_FINISH : ST_PROBE;
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: set on load, clear on transfer
  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/sorted_array_binary_search_core.sv
// Top level: configuration register, controller and datapath of the binary search block
//
// Usage:
//   query  - sink channel. mode 0 writes value into the store at slot (slots at or
//            beyond DEPTH are dropped) and gives no result. mode 1 searches the
//            first element_count entries (saturated to DEPTH) for value.
//   result - source channel. One transfer per search: found and position (low
//            10 bits of the matching index, 0 when not found).
//   APB    - register element_count at byte addresses 0 to 3 (paddr[2] low); writes to
//            addresses 4 to 7 are ignored. pready is always high.
// Timing: a write is stored without leaving IDLE, so writes can be taken back to back. A
//   search steps through PROBE (registered store read) and CMP (compare) for each
//   probe, one more PROBE that finds the range empty when nothing matched, and
//   FINISH to load the result register; the next item is taken back in IDLE.
//   The probe loop through the single store read port sets the search time. One at a time.
// Reset: clears element_count and all handshake state; store contents stay
//   undefined until written.
// Stall: a finished result waits in the output register; a following search
//   runs meanwhile and holds in its last step until that result is taken.
`timescale 1ns / 1ps

module sorted_array_binary_search_core #(
  parameter int unsigned DEPTH = sabs_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sabs_query_if.sink                    query,
  sabs_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sabs_pkg::ADDR_W-1:0]   paddr,
  input  logic [sabs_pkg::DATA_W-1:0]   pwdata,
  output logic [sabs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned IW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (IW > sabs_pkg::COUNT_W) ? IW : sabs_pkg::COUNT_W;

  logic [sabs_pkg::COUNT_W-1:0] count_q;
  logic [CW-1:0]                count_ext;
  logic [IW-1:0]                count_sat;
  logic                         reg_sel;
  sabs_pkg::cmd_t               cmd;
  sabs_pkg::sts_t               sts;

  // Register decode
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == sabs_pkg::REG_ELEMENT_COUNT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      count_q <= pwdata[sabs_pkg::COUNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? sabs_pkg::DATA_W'(count_q) : '0;

  // Clamp the searched length to the store depth
  assign count_ext = CW'(count_q);
  assign count_sat = (count_ext > CW'(DEPTH)) ? IW'(DEPTH) : IW'(count_ext);

  sabs_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (query.valid),
    .in_mode_i   (query.mode),
    .in_ready_o  (query.ready),
    .out_valid_o (result.valid),
    .out_ready_i (result.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sabs_datapath #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .count_i    (count_sat),
    .slot_i     (query.slot),
    .value_i    (query.value),
    .found_o    (result.found),
    .position_o (result.position)
  );

endmodule
